### hw/rtl/download_frame_parser_top_defines.svh
// Assertion macros for the download frame parser.
`ifndef DOWNLOAD_FRAME_PARSER_TOP_DEFINES_SVH
`define DOWNLOAD_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DFP_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define DFP_ASSERT(lbl, prop, msg)
`define DFP_NEVER(lbl, expr, msg)
`endif

`endif

### hw/rtl/dfp_pkg.sv
package dfp_pkg;

	localparam int BUF_DEPTH_DEF = 32;
	localparam int CFG_W = 17;
	localparam logic [CFG_W-1:0] ERASE_BYTES_RST = 17'd4096;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] REPLY_HDR = 8'h55;
	localparam logic [7:0] REPLY_ACK = 8'h01;
	localparam logic [7:0] REPLY_NAK = 8'h02;
	localparam logic [7:0] FRAME_DATA = 8'h01;
	localparam logic [7:0] FRAME_CTRL = 8'h02;
	localparam logic [7:0] CTRL_SET_ADDR = 8'h01;
	localparam logic [7:0] CTRL_FINISH = 8'h02;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_ERASE = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [2:0] EMIT_HDR = 3'd0;
	localparam logic [2:0] EMIT_ACK = 3'd1;
	localparam logic [2:0] EMIT_NAK = 3'd2;
	localparam logic [2:0] EMIT_ERASE = 3'd3;
	localparam logic [2:0] EMIT_WRITE = 3'd4;
	localparam logic [2:0] EMIT_DONE = 3'd5;

	typedef struct packed {
		logic addr_clr;
		logic cap_cmd;
		logic cap_len_lo;
		logic cap_len_hi;
		logic store;
		logic budget_load;
		logic write_done;
		logic idx_clr;
		logic idx_adv;
		logic addr_shift;
		logic out_load;
		logic [2:0] emit;
		logic emit_last;
	} dfp_ctl_t;

	typedef struct packed {
		logic is_sync;
		logic new_len_zero;
		logic cnt_last;
		logic sum_ok;
		logic len_over;
		logic len_zero;
		logic cmd_data;
		logic cmd_ctrl;
		logic budget_zero;
		logic idx_last;
		logic idx_zero;
		logic idx_four;
		logic b0_finish;
		logic b0_set_addr;
	} dfp_sts_t;

endpackage

### hw/rtl/dfp_ram.sv
module dfp_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/dfp_datapath.sv
module dfp_datapath #(
	parameter int BUF_DEPTH = dfp_pkg::BUF_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [dfp_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic [7:0]               rx_byte,
	input  dfp_pkg::dfp_ctl_t        ctl,
	output dfp_pkg::dfp_sts_t        sts,
	output logic [1:0]               kind,
	output logic [31:0]              flash_address,
	output logic [7:0]               data_byte,
	output logic                     last
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int IW = $clog2(BUF_DEPTH + 1);

	logic [dfp_pkg::CFG_W-1:0] erase_bytes_q;
	logic [7:0]  fcmd_q;
	logic [15:0] len_q;
	logic [15:0] cnt_q;
	logic [7:0]  sum_q;
	logic [31:0] waddr_q;
	logic [dfp_pkg::CFG_W-1:0] budget_q;
	logic [IW-1:0] idx_q;
	logic [BUF_DEPTH-1:0] vld_q;
	logic rd_vld_q;

	logic [1:0]  kind_q;
	logic [31:0] faddr_q;
	logic [7:0]  data_q;
	logic        last_q;

	logic [IW-1:0] idx_nx;
	logic [IW-1:0] rd_idx;
	logic [AW-1:0] raddr;
	logic [7:0]    rd_data;
	logic [7:0]    pbyte;
	logic          st_in;
	logic [16:0]   cnt_inc;
	logic [dfp_pkg::CFG_W-1:0] len_ext;

	assign idx_nx  = idx_q + IW'(1);
	assign rd_idx  = ctl.idx_clr ? '0 : (ctl.idx_adv ? idx_nx : idx_q);
	assign raddr   = (rd_idx < IW'(BUF_DEPTH)) ? rd_idx[AW-1:0] : idx_q[AW-1:0];
	assign st_in   = ctl.store && (cnt_q < 16'(BUF_DEPTH));
	assign pbyte   = rd_vld_q ? rd_data : 8'h00;
	assign cnt_inc = {1'b0, cnt_q} + 17'd1;
	assign len_ext = dfp_pkg::CFG_W'(len_q);

	dfp_ram #(
		.W(8),
		.D(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_in),
		.waddr(cnt_q[AW-1:0]),
		.wdata(rx_byte),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_bytes_q <= dfp_pkg::ERASE_BYTES_RST;
			fcmd_q        <= '0;
			len_q         <= '0;
			cnt_q         <= '0;
			sum_q         <= '0;
			waddr_q       <= '0;
			budget_q      <= '0;
			idx_q         <= '0;
			vld_q         <= '0;
			rd_vld_q      <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (cfg_wr_en) begin
				erase_bytes_q <= cfg_wr_data;
			end
			if (ctl.cap_cmd) begin
				fcmd_q <= rx_byte;
			end
			if (ctl.cap_len_lo) begin
				len_q <= {8'h00, rx_byte};
			end
			if (ctl.cap_len_hi) begin
				len_q[15:8] <= rx_byte;
				cnt_q       <= '0;
				sum_q       <= '0;
			end
			if (ctl.store) begin
				sum_q <= sum_q + rx_byte;
				cnt_q <= cnt_inc[15:0];
			end
			if (st_in) begin
				vld_q[cnt_q[AW-1:0]] <= 1'b1;
			end
			if (ctl.budget_load) begin
				budget_q <= erase_bytes_q;
			end
			if (ctl.write_done) begin
				waddr_q  <= waddr_q + 32'(len_q);
				budget_q <= (budget_q > len_ext) ? budget_q - len_ext : '0;
			end
			if (ctl.addr_clr) begin
				waddr_q <= '0;
			end
			if (ctl.addr_shift) begin
				waddr_q <= {pbyte, waddr_q[31:8]};
			end
			if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_adv) begin
				idx_q <= idx_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			last_q <= ctl.emit_last;
			case (ctl.emit)
				dfp_pkg::EMIT_HDR: begin
					kind_q  <= dfp_pkg::KIND_REPLY;
					faddr_q <= '0;
					data_q  <= dfp_pkg::REPLY_HDR;
				end
				dfp_pkg::EMIT_ACK: begin
					kind_q  <= dfp_pkg::KIND_REPLY;
					faddr_q <= '0;
					data_q  <= dfp_pkg::REPLY_ACK;
				end
				dfp_pkg::EMIT_NAK: begin
					kind_q  <= dfp_pkg::KIND_REPLY;
					faddr_q <= '0;
					data_q  <= dfp_pkg::REPLY_NAK;
				end
				dfp_pkg::EMIT_ERASE: begin
					kind_q  <= dfp_pkg::KIND_ERASE;
					faddr_q <= waddr_q;
					data_q  <= 8'h00;
				end
				dfp_pkg::EMIT_WRITE: begin
					kind_q  <= dfp_pkg::KIND_WRITE;
					faddr_q <= waddr_q + 32'(idx_q);
					data_q  <= pbyte;
				end
				default: begin
					kind_q  <= dfp_pkg::KIND_DONE;
					faddr_q <= '0;
					data_q  <= 8'h00;
				end
			endcase
		end
	end

	always_comb begin
		sts.is_sync      = (rx_byte == dfp_pkg::SYNC_BYTE);
		sts.new_len_zero = (rx_byte == 8'h00) && (len_q[7:0] == 8'h00);
		sts.cnt_last     = (cnt_inc >= {1'b0, len_q});
		sts.sum_ok       = (sum_q == rx_byte);
		sts.len_over     = (len_q > 16'(BUF_DEPTH));
		sts.len_zero     = (len_q == 16'h0000);
		sts.cmd_data     = (fcmd_q == dfp_pkg::FRAME_DATA);
		sts.cmd_ctrl     = (fcmd_q == dfp_pkg::FRAME_CTRL);
		sts.budget_zero  = (budget_q == '0);
		sts.idx_last     = ({1'b0, 16'(idx_q)} + 17'd1 == {1'b0, len_q});
		sts.idx_zero     = (idx_q == '0);
		sts.idx_four     = (idx_q == IW'(4));
		sts.b0_finish    = (pbyte == dfp_pkg::CTRL_FINISH);
		sts.b0_set_addr  = (pbyte == dfp_pkg::CTRL_SET_ADDR);
	end

	assign kind          = kind_q;
	assign flash_address = faddr_q;
	assign data_byte     = data_q;
	assign last          = last_q;

endmodule

### hw/rtl/dfp_ctrl.sv
module dfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	output logic              out_valid,
	input  logic              out_ready,
	input  dfp_pkg::dfp_sts_t sts,
	output dfp_pkg::dfp_ctl_t ctl
);

	localparam logic [3:0] ST_SYNC  = 4'd0;
	localparam logic [3:0] ST_CMD   = 4'd1;
	localparam logic [3:0] ST_LENLO = 4'd2;
	localparam logic [3:0] ST_LENHI = 4'd3;
	localparam logic [3:0] ST_DATA  = 4'd4;
	localparam logic [3:0] ST_SUM   = 4'd5;
	localparam logic [3:0] ST_NACK0 = 4'd6;
	localparam logic [3:0] ST_NACK1 = 4'd7;
	localparam logic [3:0] ST_ERASE = 4'd8;
	localparam logic [3:0] ST_WRITE = 4'd9;
	localparam logic [3:0] ST_ACK0  = 4'd10;
	localparam logic [3:0] ST_ACK1  = 4'd11;
	localparam logic [3:0] ST_CACK0 = 4'd12;
	localparam logic [3:0] ST_CACK1 = 4'd13;
	localparam logic [3:0] ST_FIN   = 4'd14;
	localparam logic [3:0] ST_LOAD  = 4'd15;

	logic [3:0] state_q, state_d;
	logic       armed_q, armed_d;
	logic       ovld_q;
	logic       parsing;
	logic       acc;
	logic       ld_ok;

	assign parsing  = (state_q == ST_SYNC) || (state_q == ST_CMD) || (state_q == ST_LENLO) ||
	                  (state_q == ST_LENHI) || (state_q == ST_DATA) || (state_q == ST_SUM);
	assign in_ready = parsing;
	assign acc      = in_valid && parsing;
	assign ld_ok    = !ovld_q || out_ready;

	always_comb begin
		state_d = state_q;
		armed_d = armed_q;
		ctl     = '0;
		ctl.idx_clr = parsing;
		if (acc && cmd) begin
			armed_d      = 1'b1;
			state_d      = ST_SYNC;
			ctl.addr_clr = 1'b1;
		end else if (parsing) begin
			if (acc && armed_q) begin
				case (state_q)
					ST_SYNC: begin
						if (sts.is_sync) begin
							state_d = ST_CMD;
						end
					end
					ST_CMD: begin
						ctl.cap_cmd = 1'b1;
						state_d     = ST_LENLO;
					end
					ST_LENLO: begin
						ctl.cap_len_lo = 1'b1;
						state_d        = ST_LENHI;
					end
					ST_LENHI: begin
						ctl.cap_len_hi = 1'b1;
						state_d        = sts.new_len_zero ? ST_SUM : ST_DATA;
					end
					ST_DATA: begin
						ctl.store = 1'b1;
						if (sts.cnt_last) begin
							state_d = ST_SUM;
						end
					end
					default: begin
						if (!sts.sum_ok || sts.len_over) begin
							state_d = ST_NACK0;
						end else if (sts.cmd_data) begin
							if (sts.len_zero) begin
								state_d = ST_ACK0;
							end else begin
								state_d = sts.budget_zero ? ST_ERASE : ST_WRITE;
							end
						end else if (sts.cmd_ctrl) begin
							state_d = ST_CACK0;
						end else begin
							state_d = ST_SYNC;
						end
					end
				endcase
			end
		end else begin
			case (state_q)
				ST_NACK0, ST_ACK0, ST_CACK0: begin
					if (ld_ok) begin
						ctl.out_load = 1'b1;
						ctl.emit     = dfp_pkg::EMIT_HDR;
						state_d      = state_q + 4'd1;
					end
				end
				ST_NACK1: begin
					if (ld_ok) begin
						ctl.out_load  = 1'b1;
						ctl.emit      = dfp_pkg::EMIT_NAK;
						ctl.emit_last = 1'b1;
						state_d       = ST_SYNC;
					end
				end
				ST_ERASE: begin
					if (ld_ok) begin
						ctl.out_load    = 1'b1;
						ctl.emit        = dfp_pkg::EMIT_ERASE;
						ctl.budget_load = 1'b1;
						state_d         = ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (ld_ok) begin
						ctl.out_load = 1'b1;
						ctl.emit     = dfp_pkg::EMIT_WRITE;
						ctl.idx_adv  = 1'b1;
						if (sts.idx_last) begin
							ctl.write_done = 1'b1;
							state_d        = ST_ACK0;
						end
					end
				end
				ST_ACK1: begin
					if (ld_ok) begin
						ctl.out_load  = 1'b1;
						ctl.emit      = dfp_pkg::EMIT_ACK;
						ctl.emit_last = 1'b1;
						state_d       = ST_SYNC;
					end
				end
				ST_CACK1: begin
					if (ld_ok) begin
						ctl.out_load  = 1'b1;
						ctl.emit      = dfp_pkg::EMIT_ACK;
						ctl.emit_last = !sts.b0_finish;
						if (sts.b0_finish) begin
							state_d = ST_FIN;
						end else if (sts.b0_set_addr) begin
							state_d = ST_LOAD;
						end else begin
							state_d = ST_SYNC;
						end
					end
				end
				ST_FIN: begin
					if (ld_ok) begin
						ctl.out_load  = 1'b1;
						ctl.emit      = dfp_pkg::EMIT_DONE;
						ctl.emit_last = 1'b1;
						armed_d       = 1'b0;
						state_d       = ST_SYNC;
					end
				end
				ST_LOAD: begin
					// idx k holds payload byte k on the read port
					ctl.addr_shift = !sts.idx_zero;
					ctl.idx_adv    = !sts.idx_four;
					if (sts.idx_four) begin
						state_d = ST_SYNC;
					end
				end
				default: begin
					state_d = ST_SYNC;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC;
			armed_q <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			armed_q <= armed_d;
			if (ctl.out_load) begin
				ovld_q <= 1'b1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovld_q;

endmodule

### hw/rtl/download_frame_parser_top.sv
// Firmware download frame parser. Takes one link byte (or start item) per cycle
// while parsing; the checksum beat of a good frame starts a commit during which
// in_ready is low. A data frame of N payload bytes then gives an optional erase,
// N writes and a two-byte ack, one result per cycle from a single output
// register unless out_ready stalls it; the rate is set by the one read port
// of the payload buffer. A nack gives a two-byte reply, a command frame a
// two-byte ack plus a done item after a finish, and an address load then
// reads payload bytes 0..4. No clearing pass after reset.
`include "download_frame_parser_top_defines.svh"

module download_frame_parser_top #(
	parameter int BUF_DEPTH = dfp_pkg::BUF_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [dfp_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                kind,
	output logic [31:0]               flash_address,
	output logic [7:0]                data_byte,
	output logic                      last
);

	dfp_pkg::dfp_ctl_t ctl;
	dfp_pkg::dfp_sts_t sts;

	dfp_datapath #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.rx_byte      (rx_byte),
		.ctl          (ctl),
		.sts          (sts),
		.kind         (kind),
		.flash_address(flash_address),
		.data_byte    (data_byte),
		.last         (last)
	);

	dfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	`DFP_ASSERT(a_no_overwrite, ctl.out_load |-> (!out_valid || out_ready), "result overwritten")
	`DFP_ASSERT(a_last_frees, (ctl.out_load && ctl.emit_last) |-> ##[1:6] in_ready, "not ready after last")
	`DFP_NEVER(a_commit_excl, ctl.idx_adv && in_ready, "commit overlaps input")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = dfp_pkg::BUF_DEPTH_DEF;
	localparam int DW = $clog2(DEPTH);
	localparam int CW = dfp_pkg::CFG_W;
	localparam logic [7:0] NO_REPLY = 8'h00;

	typedef enum logic [2:0] {
		SEEK_SYNC,
		GET_CMD,
		GET_LEN_LO,
		GET_LEN_HI,
		GET_DATA,
		GET_SUM
	} link_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [7:0]  data;
		logic        last;
	} flash_res_t;

	typedef struct packed {
		logic       start;
		logic [7:0] val;
		logic       fixed;
		logic [7:0] reply;
		logic       fin;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CW-1:0]    cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             cmd = 1'b0;
	logic [7:0]       rx_byte = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       kind;
	logic [31:0]      flash_address;
	logic [7:0]       data_byte;
	logic             last;

	// predictor state
	logic             link_armed = 1'b0;
	link_phase_t      link_phase = SEEK_SYNC;
	logic [7:0]       frm_cmd = 8'h00;
	logic [15:0]      frm_len = 16'h0000;
	logic [15:0]      frm_cnt = 16'h0000;
	logic [7:0]       frm_sum = 8'h00;
	logic [7:0]       frm_buf [DEPTH];
	logic [31:0]      next_addr = 32'h0;
	logic [CW-1:0]    erase_left = '0;
	logic [CW-1:0]    erase_size = dfp_pkg::ERASE_BYTES_RST;

	flash_res_t       beat_q [$];
	flash_res_t       flash_q [$];

	int unsigned      n_err = 0;
	int unsigned      n_items = 0;
	int unsigned      send_idle = 18;
	int unsigned      recv_idle = 53;
	logic             hold_req = 1'b0;

	logic             fixed_row = 1'b0;
	logic [7:0]       fixed_reply = NO_REPLY;
	logic             fixed_fin = 1'b0;

	dir_row_t dir_rows [24] = '{
		'{1'b0, dfp_pkg::SYNC_BYTE,   1'b1, NO_REPLY,           1'b0},
		'{1'b1, 8'h00,                1'b1, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::SYNC_BYTE,   1'b0, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::FRAME_DATA,  1'b0, NO_REPLY,           1'b0},
		'{1'b0, 8'h02,                1'b0, NO_REPLY,           1'b0},
		'{1'b0, 8'h00,                1'b0, NO_REPLY,           1'b0},
		'{1'b0, 8'h00,                1'b0, NO_REPLY,           1'b0},
		'{1'b0, 8'hFF,                1'b0, NO_REPLY,           1'b0},
		'{1'b0, 8'hFF,                1'b0, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::SYNC_BYTE,   1'b0, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::FRAME_DATA,  1'b0, NO_REPLY,           1'b0},
		'{1'b1, 8'hFF,                1'b1, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::SYNC_BYTE,   1'b1, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::FRAME_DATA,  1'b1, NO_REPLY,           1'b0},
		'{1'b0, 8'h00,                1'b1, NO_REPLY,           1'b0},
		'{1'b0, 8'h00,                1'b1, NO_REPLY,           1'b0},
		'{1'b0, 8'h07,                1'b1, dfp_pkg::REPLY_NAK, 1'b0},
		'{1'b0, dfp_pkg::SYNC_BYTE,   1'b1, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::FRAME_CTRL,  1'b1, NO_REPLY,           1'b0},
		'{1'b0, 8'h01,                1'b1, NO_REPLY,           1'b0},
		'{1'b0, 8'h00,                1'b1, NO_REPLY,           1'b0},
		'{1'b0, dfp_pkg::CTRL_FINISH, 1'b1, NO_REPLY,           1'b0},
		'{1'b0, 8'h02,                1'b1, dfp_pkg::REPLY_ACK, 1'b1},
		'{1'b0, dfp_pkg::SYNC_BYTE,   1'b1, NO_REPLY,           1'b0}
	};

	download_frame_parser_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.flash_address (flash_address),
		.data_byte     (data_byte),
		.last          (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		foreach (frm_buf[i])
			frm_buf[i] = 8'h00;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		n_err++;
	endtask

	task automatic add_result(input logic [1:0] k, input logic [31:0] a, input logic [7:0] d);
		beat_q.push_back(flash_res_t'{k, a, d, 1'b0});
	endtask

	task automatic add_reply(input logic [7:0] code);
		add_result(dfp_pkg::KIND_REPLY, 32'h0, dfp_pkg::REPLY_HDR);
		add_result(dfp_pkg::KIND_REPLY, 32'h0, code);
	endtask

	// advance the frame parser by one beat, results land in beat_q
	task automatic parse_link_beat(input logic start, input logic [7:0] b);
		beat_q.delete();
		if (start) begin
			link_armed = 1'b1;
			link_phase = SEEK_SYNC;
			next_addr = 32'h0;
			return;
		end
		if (!link_armed)
			return;
		case (link_phase)
		SEEK_SYNC: begin
			if (b == dfp_pkg::SYNC_BYTE)
				link_phase = GET_CMD;
		end
		GET_CMD: begin
			frm_cmd = b;
			link_phase = GET_LEN_LO;
		end
		GET_LEN_LO: begin
			frm_len = {8'h00, b};
			link_phase = GET_LEN_HI;
		end
		GET_LEN_HI: begin
			frm_len[15:8] = b;
			frm_cnt = 16'h0;
			frm_sum = 8'h00;
			link_phase = (frm_len != 16'h0) ? GET_DATA : GET_SUM;
		end
		GET_DATA: begin
			frm_sum = frm_sum + b;
			if (frm_cnt < DEPTH)
				frm_buf[frm_cnt[DW-1:0]] = b;
			frm_cnt = frm_cnt + 16'h1;
			if (frm_cnt >= frm_len)
				link_phase = GET_SUM;
		end
		default: begin
			link_phase = SEEK_SYNC;
			if (frm_sum != b || frm_len > DEPTH) begin
				add_reply(dfp_pkg::REPLY_NAK);
			end else if (frm_cmd == dfp_pkg::FRAME_DATA) begin
				if (frm_len != 16'h0) begin
					if (erase_left == '0) begin
						add_result(dfp_pkg::KIND_ERASE, next_addr, 8'h00);
						erase_left = erase_size;
					end
					for (int i = 0; i < int'(frm_len); i++)
						add_result(dfp_pkg::KIND_WRITE, next_addr + 32'(i),
							frm_buf[DW'(i)]);
					if (erase_left > CW'(frm_len))
						erase_left = erase_left - CW'(frm_len);
					else
						erase_left = '0;
				end
				next_addr = next_addr + 32'(frm_len);
				add_reply(dfp_pkg::REPLY_ACK);
			end else if (frm_cmd == dfp_pkg::FRAME_CTRL) begin
				add_reply(dfp_pkg::REPLY_ACK);
				if (frm_buf[0] == dfp_pkg::CTRL_FINISH) begin
					add_result(dfp_pkg::KIND_DONE, 32'h0, 8'h00);
					link_armed = 1'b0;
				end else if (frm_buf[0] == dfp_pkg::CTRL_SET_ADDR) begin
					next_addr = {frm_buf[4], frm_buf[3], frm_buf[2], frm_buf[1]};
				end
			end
		end
		endcase
	endtask

	task automatic send_beat(input logic start, input logic [7:0] b);
		logic counted;
		flash_res_t r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= start;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		counted = start | link_armed;
		parse_link_beat(start, b);
		if (fixed_row) begin
			beat_q.delete();
			if (fixed_reply != NO_REPLY)
				add_reply(fixed_reply);
			if (fixed_fin)
				add_result(dfp_pkg::KIND_DONE, 32'h0, 8'h00);
		end
		foreach (beat_q[i]) begin
			r = beat_q[i];
			r.last = (i == beat_q.size() - 1);
			flash_q.push_back(r);
		end
		if (counted)
			n_items++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (flash_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_erase_size(input logic [CW-1:0] val);
		drain_results();
		repeat (32) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		erase_size = val;
	endtask

	task automatic send_frame(input logic [7:0] fcmd, input logic [15:0] len,
		input logic [7:0] first);
		logic [7:0] sum;
		logic [7:0] b;
		if (!link_armed || link_phase != SEEK_SYNC)
			send_beat(1'b1, 8'($urandom_range(255)));
		send_beat(1'b0, dfp_pkg::SYNC_BYTE);
		send_beat(1'b0, fcmd);
		send_beat(1'b0, len[7:0]);
		send_beat(1'b0, len[15:8]);
		sum = 8'h00;
		for (int i = 0; i < int'(len); i++) begin
			b = (i == 0) ? first : 8'($urandom_range(255));
			sum = sum + b;
			send_beat(1'b0, b);
		end
		if ($urandom_range(99) < 85)
			send_beat(1'b0, sum);
		else
			send_beat(1'b0, sum + 8'($urandom_range(255, 1)));
	endtask

	task automatic random_traffic(input int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		stop_at = n_items + quota;
		while (n_items < stop_at) begin
			pick = $urandom_range(99);
			if (!link_armed) begin
				send_beat(pick < 75, 8'($urandom_range(255)));
			end else if (pick < 42) begin
				len = $urandom_range(99);
				if (len < 80)
					len = $urandom_range(8);
				else if (len < 90)
					len = DEPTH;
				else
					len = $urandom_range(DEPTH + 8, DEPTH + 1);
				send_frame(dfp_pkg::FRAME_DATA, 16'(len), 8'($urandom_range(255)));
			end else if (pick < 56) begin
				send_frame(dfp_pkg::FRAME_CTRL, 16'($urandom_range(7, 5)),
					dfp_pkg::CTRL_SET_ADDR);
			end else if (pick < 62) begin
				send_frame(dfp_pkg::FRAME_CTRL, 16'($urandom_range(3, 1)),
					dfp_pkg::CTRL_FINISH);
			end else if (pick < 70) begin
				send_frame(dfp_pkg::FRAME_CTRL, 16'($urandom_range(3)),
					8'($urandom_range(255)));
			end else if (pick < 78) begin
				send_frame(8'($urandom_range(255, 3)), 16'($urandom_range(4)),
					8'($urandom_range(255)));
			end else begin
				// cut-off frame or line noise, sometimes dropped by a start beat
				if (pick < 90)
					send_beat(1'b0, dfp_pkg::SYNC_BYTE);
				repeat ($urandom_range(4, 1))
					send_beat(1'b0, 8'($urandom_range(255)));
				if (pick[0])
					send_beat(1'b1, 8'($urandom_range(255)));
			end
			if ($urandom_range(7) == 0)
				drain_results();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			fixed_row = dir_rows[i].fixed;
			fixed_reply = dir_rows[i].reply;
			fixed_fin = dir_rows[i].fin;
			send_beat(dir_rows[i].start, dir_rows[i].val);
		end
		fixed_row = 1'b0;

		set_erase_size(CW'(1));
		random_traffic(15);
		set_erase_size(CW'(65536));
		random_traffic(15);

		send_idle = 53;
		recv_idle = 18;
		set_erase_size(CW'($urandom_range(65536, 1)));
		random_traffic(15);

		send_idle = 0;
		recv_idle = 0;
		set_erase_size(CW'(40));
		hold_req = 1'b1;
		send_frame(dfp_pkg::FRAME_DATA, 16'(DEPTH), 8'($urandom_range(255)));
		random_traffic(15);

		drain_results();
		repeat (64) @(posedge clk);
		if (n_err == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// output side: random ready, plus one long hold-off on request
	initial begin
		int unsigned hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 400;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		flash_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (flash_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat kind %0d addr %h data %h",
					kind, flash_address, data_byte));
			end else begin
				want = flash_q.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (flash_address !== want.addr)
					report_mismatch($sformatf("flash_address %h, want %h",
						flash_address, want.addr));
				if (data_byte !== want.data)
					report_mismatch($sformatf("data_byte %h, want %h", data_byte, want.data));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
			end
		end
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

endmodule

### download_frame_parser_top.f
+incdir+hw/rtl
hw/rtl/dfp_pkg.sv
hw/rtl/dfp_ram.sv
hw/rtl/dfp_datapath.sv
hw/rtl/dfp_ctrl.sv
hw/rtl/download_frame_parser_top.sv
tb/tb_top.sv
